// ----- rtl/assert_macros.svh -----
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define BPA_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define BPA_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/bpa_pkg.sv -----
package bpa_pkg;

    localparam int WORD_BITS = 64;

    typedef struct packed {
        logic [2:0]  req_type;
        logic [8:0]  run_length;
        logic [15:0] page_index;
    } req_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] page_start;
        logic        is_user;
        logic [16:0] free_pages;
    } rsp_t;

    localparam logic [2:0] REQ_INIT  = 3'd0;
    localparam logic [2:0] REQ_KRUN  = 3'd1;
    localparam logic [2:0] REQ_URUN  = 3'd2;
    localparam logic [2:0] REQ_PTAB  = 3'd3;
    localparam logic [2:0] REQ_FREE  = 3'd4;
    localparam logic [2:0] REQ_QUERY = 3'd5;

    localparam logic [1:0] STAT_OK      = 2'd0;
    localparam logic [1:0] STAT_NOSPACE = 2'd1;
    localparam logic [1:0] STAT_BAD     = 2'd2;

    localparam logic [1:0] REG_TOTAL = 2'd0;
    localparam logic [1:0] REG_RSV   = 2'd1;
    localparam logic [1:0] REG_POOL  = 2'd2;

    localparam logic [16:0] TOTAL_RST = 17'h10000;
    localparam logic [16:0] RSV_RST   = 17'd0;
    localparam logic [16:0] POOL_RST  = 17'd4096;

    typedef enum logic [3:0] {
        S_IDLE,
        S_INIT,
        S_SC_RD,
        S_SC_EV,
        S_SC_DEC,
        S_TK_RD,
        S_TK_WR,
        S_AC_RD,
        S_AC_EX,
        S_DONE
    } state_t;

    typedef enum logic [1:0] {
        MODE_RUN,
        MODE_POOL,
        MODE_FB
    } mode_t;

    typedef struct packed {
        logic       pre_hit;
        logic       win_hit;
        logic [5:0] win_pos;
        logic [8:0] run_out;
    } eval_res_t;

endpackage

// ----- rtl/bpa_stream_if.sv -----
interface bpa_stream_if #(parameter type payload_t = logic);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

// ----- rtl/bpa_map_mem.sv -----
module bpa_map_mem #(
    parameter int WORDS = 1024,
    parameter int AW    = 10
) (
    input  logic          clk,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [63:0]   rd_used,
    output logic [63:0]   rd_owner,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [63:0]   wr_used,
    input  logic [63:0]   wr_owner
);
    import bpa_pkg::*;

    logic [WORD_BITS-1:0] used_mem  [WORDS];
    logic [WORD_BITS-1:0] owner_mem [WORDS];
    logic [WORD_BITS-1:0] used_reg;
    logic [WORD_BITS-1:0] owner_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            used_mem[wr_addr]  <= wr_used;
            owner_mem[wr_addr] <= wr_owner;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            used_reg  <= used_mem[rd_addr];
            owner_reg <= owner_mem[rd_addr];
        end
    end

    assign rd_used  = used_reg;
    assign rd_owner = owner_reg;
endmodule

// ----- rtl/bpa_word_eval.sv -----
module bpa_word_eval (
    input  logic                clk,
    input  logic                load,
    input  logic [63:0]         free_word,
    input  logic [8:0]          len,
    input  logic [8:0]          run_in,
    output bpa_pkg::eval_res_t  res
);
    import bpa_pkg::*;

    // e_reg[k][b]: the 2**k pages ending at bit b are all free
    logic [WORD_BITS-1:0] e_reg  [7];
    logic [WORD_BITS-1:0] e_next [7];
    logic [6:0]           tz_reg;
    logic [6:0]           tz_next;
    logic [6:0]           top_reg;
    logic [6:0]           top_next;

    always_comb
    begin
        e_next[0] = free_word;
        for (int k = 0; k < 6; k++)
        begin
            e_next[k+1] = e_next[k] & (e_next[k] << (1 << k));
        end
        tz_next = 7'd64;
        for (int b = 63; b >= 0; b--)
        begin
            if (!free_word[b])
            begin
                tz_next = 7'(b);
            end
        end
        top_next = 7'd64;
        for (int b = 0; b < 64; b++)
        begin
            if (!free_word[b])
            begin
                top_next = 7'(63 - b);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            e_reg   <= e_next;
            tz_reg  <= tz_next;
            top_reg <= top_next;
        end
    end

    logic [63:0] acc;
    logic [6:0]  l7;
    logic [5:0]  pos;
    logic [9:0]  sum;
    logic        win_ok;

    always_comb
    begin
        l7  = len[6:0];
        acc = '1;
        for (int k = 0; k < 7; k++)
        begin
            if (l7[k])
            begin
                acc = acc & (e_reg[k] << (l7 & ~7'((2 << k) - 1)));
            end
        end
        win_ok = (len[8:7] == 2'd0) && (len != 9'd0);
        pos = 6'd0;
        for (int b = 63; b >= 0; b--)
        begin
            if (acc[b])
            begin
                pos = 6'(b);
            end
        end
        sum = {1'b0, run_in} + {3'b0, tz_reg};
        res.pre_hit = (sum >= {1'b0, len});
        res.win_hit = win_ok && (|acc);
        res.win_pos = pos;
        res.run_out = (tz_reg == 7'd64) ? 9'(run_in + 9'd64) : {2'b0, top_reg};
    end
endmodule

// ----- rtl/bitmap_page_allocator.sv -----
// Page allocator: used and owner bitmaps in one 64-bit-word memory pair.
// Init sweeps every map word, one per cycle. Run search reads, evaluates and decides on
// each map word scanned, then reads and writes back each word of the run. Free and query
// read one map word, then update or inspect it. One request in flight; the output register
// frees the input. Reset clears control state; maps are undefined until the first init request.
`include "assert_macros.svh"

module bitmap_page_allocator #(
    parameter int NUM_PAGES    = 65536,
    parameter int MAX_RUN      = 256,
    parameter int TOP_RESERVED = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    bpa_stream_if.sink   req,
    bpa_stream_if.source rsp,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import bpa_pkg::*;

    localparam int WORDS = (NUM_PAGES + 63) / 64;
    localparam int WD_W  = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int PG_W  = WD_W + 6;
    localparam int CNT_W = PG_W + 1;
    localparam int XW    = ((CNT_W > 17) ? CNT_W : 17) + 1;

    localparam logic [WD_W-1:0]  LAST_W    = WD_W'(WORDS - 1);
    localparam logic [CNT_W-1:0] TOP_C     = CNT_W'(TOP_RESERVED);
    localparam logic [16:0]      MAX_RUN_C = 17'(MAX_RUN);

    // Configuration registers, sampled only by init
    logic [16:0] total_reg, total_next;
    logic [16:0] rsv_reg, rsv_next;
    logic [16:0] pool_reg, pool_next;

    // Control state
    state_t            state_reg, state_next;
    mode_t             mode_reg, mode_next;
    logic              out_valid_reg, out_valid_next;
    logic [CNT_W-1:0]  managed_reg, managed_next;
    logic [CNT_W-1:0]  free_count_reg, free_count_next;
    logic [CNT_W-1:0]  res_reg, res_next;
    logic [CNT_W-1:0]  pf_reg, pf_next;
    logic [CNT_W-1:0]  pe_reg, pe_next;
    logic              pool_act_reg, pool_act_next;

    // Per-request working registers
    logic [WD_W-1:0]   w_reg, w_next;
    logic [WD_W-1:0]   last_reg, last_next;
    logic [8:0]        len_reg, len_next;
    logic [8:0]        r_reg, r_next;
    logic              user_req_reg, user_req_next;
    logic              is_free_reg, is_free_next;
    logic [PG_W-1:0]   idx_reg, idx_next;
    logic [CNT_W-1:0]  tk_lo_reg, tk_lo_next;
    logic [CNT_W-1:0]  tk_hi_reg, tk_hi_next;
    logic [1:0]        status_reg, status_next;
    logic [PG_W-1:0]   start_reg, start_next;
    logic              user_reg, user_next;
    rsp_t              rsp_reg, rsp_next;

    // Map memory ports
    logic              mem_rd_en;
    logic [WD_W-1:0]   mem_rd_addr;
    logic [63:0]       rd_used;
    logic [63:0]       rd_owner;
    logic              mem_wr_en;
    logic [WD_W-1:0]   mem_wr_addr;
    logic [63:0]       mem_wr_used;
    logic [63:0]       mem_wr_owner;

    logic              ev_load;
    logic [63:0]       ev_free;
    eval_res_t         ev_res;

    bpa_map_mem #(
        .WORDS (WORDS),
        .AW    (WD_W)
    ) u_map (
        .clk      (clk),
        .rd_en    (mem_rd_en),
        .rd_addr  (mem_rd_addr),
        .rd_used  (rd_used),
        .rd_owner (rd_owner),
        .wr_en    (mem_wr_en),
        .wr_addr  (mem_wr_addr),
        .wr_used  (mem_wr_used),
        .wr_owner (mem_wr_owner)
    );

    bpa_word_eval u_eval (
        .clk       (clk),
        .load      (ev_load),
        .free_word (ev_free),
        .len       (len_reg),
        .run_in    (r_reg),
        .res       (ev_res)
    );

    // Bits of map word w that fall inside pages [lo, hi)
    function automatic logic [63:0] range_mask(
        input logic [WD_W-1:0]  w,
        input logic [CNT_W-1:0] lo,
        input logic [CNT_W-1:0] hi
    );
        logic [WD_W:0] wx;
        logic [63:0]   ge;
        logic [63:0]   lt;
        wx = {1'b0, w};
        if (wx < lo[CNT_W-1:6])
        begin
            ge = '0;
        end
        else if (wx > lo[CNT_W-1:6])
        begin
            ge = '1;
        end
        else
        begin
            ge = '1 << lo[5:0];
        end
        if (wx < hi[CNT_W-1:6])
        begin
            lt = '1;
        end
        else if (wx > hi[CNT_W-1:6])
        begin
            lt = '0;
        end
        else
        begin
            lt = ~('1 << hi[5:0]);
        end
        return ge & lt;
    endfunction

    // APB configuration port: no wait states
    assign pready = 1'b1;

    always_comb
    begin
        total_next = total_reg;
        rsv_next   = rsv_reg;
        pool_next  = pool_reg;
        if (psel && penable && pwrite)
        begin
            case (paddr[3:2])
                REG_TOTAL: total_next = pwdata[16:0];
                REG_RSV:   rsv_next   = pwdata[16:0];
                REG_POOL:  pool_next  = pwdata[16:0];
                default:   total_next = total_reg;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            REG_TOTAL: prdata = 32'(total_reg);
            REG_RSV:   prdata = 32'(rsv_reg);
            REG_POOL:  prdata = 32'(pool_reg);
            default:   prdata = 32'd0;
        endcase
    end

    assign req.ready   = (state_reg == S_IDLE);
    assign rsp.valid   = out_valid_reg;
    assign rsp.payload = rsp_reg;

    // Helpers derived from registered state
    logic [CNT_W-1:0] mm1;
    logic [CNT_W-1:0] pe_m1;
    logic [CNT_W-1:0] mt;
    logic             top_on;
    logic [CNT_W-1:0] base;
    logic [CNT_W-1:0] next_base;
    logic [CNT_W-1:0] init_a;
    logic [CNT_W-1:0] mng_in;
    logic [63:0]      tk_mask;
    logic [63:0]      init_mask;
    logic [5:0]       bit_sel;

    assign mm1       = managed_reg - CNT_W'(1);
    assign pe_m1     = pe_reg - CNT_W'(1);
    assign top_on    = (managed_reg > TOP_C);
    assign mt        = managed_reg - TOP_C;
    assign base      = {1'b0, w_reg, 6'b0};
    assign next_base = base + CNT_W'(64);
    assign init_a    = pool_act_reg ? pe_reg : res_reg;
    assign tk_mask   = range_mask(w_reg, tk_lo_reg, tk_hi_reg);
    assign bit_sel   = idx_reg[5:0];
    assign mng_in    = (XW'(total_reg) > XW'(NUM_PAGES)) ? CNT_W'(NUM_PAGES)
                                                         : CNT_W'(total_reg);

    // Init pattern: reserved pages, active pool, top pages; owner all kernel
    always_comb
    begin
        init_mask = range_mask(w_reg, '0, res_reg);
        if (pool_act_reg)
        begin
            init_mask = init_mask | range_mask(w_reg, pf_reg, pe_reg);
        end
        if (top_on)
        begin
            init_mask = init_mask | range_mask(w_reg, mt, managed_reg);
        end
    end

    // Main controller
    always_comb
    begin
        state_next      = state_reg;
        mode_next       = mode_reg;
        managed_next    = managed_reg;
        free_count_next = free_count_reg;
        res_next        = res_reg;
        pf_next         = pf_reg;
        pe_next         = pe_reg;
        pool_act_next   = pool_act_reg;
        w_next          = w_reg;
        last_next       = last_reg;
        len_next        = len_reg;
        r_next          = r_reg;
        user_req_next   = user_req_reg;
        is_free_next    = is_free_reg;
        idx_next        = idx_reg;
        tk_lo_next      = tk_lo_reg;
        tk_hi_next      = tk_hi_reg;
        status_next     = status_reg;
        start_next      = start_reg;
        user_next       = user_reg;
        rsp_next        = rsp_reg;
        out_valid_next  = out_valid_reg && !rsp.ready;

        mem_rd_en    = 1'b0;
        mem_rd_addr  = w_reg;
        mem_wr_en    = 1'b0;
        mem_wr_addr  = w_reg;
        mem_wr_used  = rd_used;
        mem_wr_owner = rd_owner;
        ev_load      = 1'b0;
        ev_free      = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    status_next = STAT_OK;
                    start_next  = '0;
                    user_next   = 1'b0;
                    state_next  = S_DONE;
                    case (req.payload.req_type)
                        REQ_INIT:
                        begin
                            // Latch geometry now; the sweep rewrites every word
                            managed_next = mng_in;
                            res_next     = (XW'(rsv_reg) > XW'(mng_in)) ? mng_in
                                                                        : CNT_W'(rsv_reg);
                            if ((XW'(rsv_reg) + XW'(pool_reg)) < XW'(mng_in))
                            begin
                                pool_act_next = 1'b1;
                                pf_next       = CNT_W'(rsv_reg);
                                pe_next       = CNT_W'(XW'(rsv_reg) + XW'(pool_reg));
                            end
                            else
                            begin
                                pool_act_next = 1'b0;
                                pf_next       = '0;
                                pe_next       = '0;
                            end
                            w_next     = '0;
                            state_next = S_INIT;
                        end
                        REQ_KRUN, REQ_URUN:
                        begin
                            if ((req.payload.run_length == 9'd0) ||
                                ({8'b0, req.payload.run_length} > MAX_RUN_C) ||
                                (XW'(req.payload.run_length) > XW'(managed_reg)))
                            begin
                                status_next = STAT_BAD;
                            end
                            else
                            begin
                                len_next      = req.payload.run_length;
                                user_req_next = (req.payload.req_type == REQ_URUN);
                                mode_next     = MODE_RUN;
                                w_next        = '0;
                                last_next     = mm1[CNT_W-2:6];
                                r_next        = '0;
                                state_next    = S_SC_RD;
                            end
                        end
                        REQ_PTAB:
                        begin
                            len_next      = 9'd1;
                            user_req_next = 1'b0;
                            r_next        = '0;
                            if (managed_reg == '0)
                            begin
                                status_next = STAT_BAD;
                            end
                            else if (pool_act_reg && (pe_reg > pf_reg))
                            begin
                                mode_next  = MODE_POOL;
                                w_next     = pf_reg[CNT_W-2:6];
                                last_next  = pe_m1[CNT_W-2:6];
                                state_next = S_SC_RD;
                            end
                            else
                            begin
                                mode_next  = MODE_FB;
                                w_next     = '0;
                                last_next  = mm1[CNT_W-2:6];
                                state_next = S_SC_RD;
                            end
                        end
                        REQ_FREE, REQ_QUERY:
                        begin
                            if (XW'(req.payload.page_index) >= XW'(managed_reg))
                            begin
                                status_next = STAT_BAD;
                            end
                            else
                            begin
                                idx_next     = PG_W'(req.payload.page_index);
                                is_free_next = (req.payload.req_type == REQ_FREE);
                                state_next   = S_AC_RD;
                            end
                        end
                        default:
                        begin
                            status_next = STAT_BAD;
                        end
                    endcase
                end
            end

            S_INIT:
            begin
                mem_wr_en    = 1'b1;
                mem_wr_used  = init_mask;
                mem_wr_owner = '0;
                if (w_reg == LAST_W)
                begin
                    // Free pages = managed minus the union of the reserved ranges
                    if (top_on)
                    begin
                        free_count_next = (mt > init_a) ? (mt - init_a) : '0;
                    end
                    else
                    begin
                        free_count_next = managed_reg - init_a;
                    end
                    state_next = S_DONE;
                end
                else
                begin
                    w_next = w_reg + WD_W'(1);
                end
            end

            S_SC_RD:
            begin
                mem_rd_en  = 1'b1;
                state_next = S_SC_EV;
            end

            S_SC_EV:
            begin
                // Pages outside the search window count as used
                ev_load = 1'b1;
                if (mode_reg == MODE_POOL)
                begin
                    ev_free = ~rd_used & range_mask(w_reg, pf_reg, pe_reg);
                end
                else
                begin
                    ev_free = ~rd_used & range_mask(w_reg, '0, managed_reg);
                end
                state_next = S_SC_DEC;
            end

            S_SC_DEC:
            begin
                if (ev_res.pre_hit)
                begin
                    // Run begins at bit 0 of this word or in an earlier word and ends in this one
                    tk_lo_next = base - CNT_W'(r_reg);
                    tk_hi_next = base - CNT_W'(r_reg) + CNT_W'(len_reg);
                    w_next     = tk_lo_next[CNT_W-2:6];
                    state_next = S_TK_RD;
                end
                else if (ev_res.win_hit)
                begin
                    tk_hi_next = base + CNT_W'(ev_res.win_pos) + CNT_W'(1);
                    tk_lo_next = base + CNT_W'(ev_res.win_pos) + CNT_W'(1)
                                 - CNT_W'(len_reg);
                    w_next     = tk_lo_next[CNT_W-2:6];
                    state_next = S_TK_RD;
                end
                else if (w_reg == last_reg)
                begin
                    if (mode_reg == MODE_POOL)
                    begin
                        // Pool exhausted: fall back to any single kernel page
                        mode_next  = MODE_FB;
                        w_next     = '0;
                        last_next  = mm1[CNT_W-2:6];
                        r_next     = '0;
                        state_next = S_SC_RD;
                    end
                    else
                    begin
                        status_next = STAT_NOSPACE;
                        start_next  = '0;
                        state_next  = S_DONE;
                    end
                end
                else
                begin
                    r_next     = ev_res.run_out;
                    w_next     = w_reg + WD_W'(1);
                    state_next = S_SC_RD;
                end
            end

            S_TK_RD:
            begin
                mem_rd_en  = 1'b1;
                state_next = S_TK_WR;
            end

            S_TK_WR:
            begin
                mem_wr_en   = 1'b1;
                mem_wr_used = rd_used | tk_mask;
                if ((mode_reg == MODE_RUN) && user_req_reg)
                begin
                    mem_wr_owner = rd_owner | tk_mask;
                end
                else
                begin
                    mem_wr_owner = rd_owner & ~tk_mask;
                end
                if (next_base >= tk_hi_reg)
                begin
                    // Every page of the run was free
                    free_count_next = free_count_reg - CNT_W'(len_reg);
                    start_next      = tk_lo_reg[PG_W-1:0];
                    status_next     = STAT_OK;
                    state_next      = S_DONE;
                end
                else
                begin
                    w_next     = w_reg + WD_W'(1);
                    state_next = S_TK_RD;
                end
            end

            S_AC_RD:
            begin
                mem_rd_en   = 1'b1;
                mem_rd_addr = idx_reg[PG_W-1:6];
                state_next  = S_AC_EX;
            end

            S_AC_EX:
            begin
                mem_wr_addr = idx_reg[PG_W-1:6];
                if (is_free_reg)
                begin
                    // Freeing a free page is a no-op; owner bit stays
                    if (rd_used[bit_sel])
                    begin
                        mem_wr_en       = 1'b1;
                        mem_wr_used     = rd_used & ~(64'd1 << bit_sel);
                        free_count_next = free_count_reg + CNT_W'(1);
                    end
                end
                else
                begin
                    user_next = rd_owner[bit_sel];
                end
                state_next = S_DONE;
            end

            S_DONE:
            begin
                // Hand the result to the output register once it is free
                if (!out_valid_reg || rsp.ready)
                begin
                    rsp_next.status     = status_reg;
                    rsp_next.page_start = 16'(start_reg);
                    rsp_next.is_user    = user_reg;
                    rsp_next.free_pages = 17'(free_count_reg);
                    out_valid_next      = 1'b1;
                    state_next          = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg      <= TOTAL_RST;
            rsv_reg        <= RSV_RST;
            pool_reg       <= POOL_RST;
            state_reg      <= S_IDLE;
            mode_reg       <= MODE_RUN;
            out_valid_reg  <= 1'b0;
            managed_reg    <= '0;
            free_count_reg <= '0;
            res_reg        <= '0;
            pf_reg         <= '0;
            pe_reg         <= '0;
            pool_act_reg   <= 1'b0;
        end
        else
        begin
            total_reg      <= total_next;
            rsv_reg        <= rsv_next;
            pool_reg       <= pool_next;
            state_reg      <= state_next;
            mode_reg       <= mode_next;
            out_valid_reg  <= out_valid_next;
            managed_reg    <= managed_next;
            free_count_reg <= free_count_next;
            res_reg        <= res_next;
            pf_reg         <= pf_next;
            pe_reg         <= pe_next;
            pool_act_reg   <= pool_act_next;
        end
    end

    always_ff @(posedge clk)
    begin
        w_reg        <= w_next;
        last_reg     <= last_next;
        len_reg      <= len_next;
        r_reg        <= r_next;
        user_req_reg <= user_req_next;
        is_free_reg  <= is_free_next;
        idx_reg      <= idx_next;
        tk_lo_reg    <= tk_lo_next;
        tk_hi_reg    <= tk_hi_next;
        status_reg   <= status_next;
        start_reg    <= start_next;
        user_reg     <= user_next;
        rsp_reg      <= rsp_next;
    end

    `BPA_ASSERT_IMP(a_no_rw_clash, clk, rst_n, mem_wr_en && mem_rd_en, mem_wr_addr != mem_rd_addr, "map read and write hit the same word")
    `BPA_ASSERT_IMP(a_free_bound, clk, rst_n, state_reg == S_IDLE, free_count_reg <= managed_reg, "free count exceeds managed pages")
    `BPA_ASSERT_NXT(a_accept_busy, clk, rst_n, req.valid && req.ready, state_reg != S_IDLE, "accepted transaction left controller idle")
endmodule

// ----- dv/tb_bitmap_page_allocator.sv -----
`timescale 1ns / 1ps

module tb_bitmap_page_allocator;
    import bpa_pkg::*;

    localparam int PAGES      = 65536;
    localparam int RUN_MAX    = 256;
    localparam int TOP_RSV    = 16;
    localparam int CYCLE_CAP  = 4000000;
    localparam int DRAIN_WAIT = 40;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    bpa_stream_if #(.payload_t(req_t)) req_ch ();
    bpa_stream_if #(.payload_t(rsp_t)) rsp_ch ();

    bitmap_page_allocator dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req_ch),
        .rsp     (rsp_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // ------------------------------------------------------------------
    // Allocator shadow: its own copy of the maps, the registers and the
    // latched layout from the last init.
    // ------------------------------------------------------------------
    bit          page_used [PAGES];
    bit          page_user [PAGES];
    int          reg_total;
    int          reg_rsv;
    int          reg_pool;
    int          managed_cnt;
    int          free_cnt;
    bit          pool_on;
    int          pool_lo;
    int          pool_hi;

    req_t        pending_reqs [$];
    rsp_t        expected_rsps [$];

    int          mismatches;
    int          cycle_cnt;
    int          hold_kick;
    int          hold_seen;

    // Mark one page used with the given owner; the free count drops only
    // when the page was free.
    function automatic void claim_page(int p, bit user);
        if (p >= PAGES)
            return;
        if (!page_used[p])
        begin
            page_used[p] = 1'b1;
            if (free_cnt > 0)
                free_cnt--;
        end
        page_user[p] = user;
    endfunction

    // Lowest run of len free pages below the managed count.
    function automatic bit first_fit(int len, output int start);
        int run;
        run = 0;
        start = 0;
        for (int p = 0; p < managed_cnt; p++)
        begin
            if (page_used[p])
                run = 0;
            else
            begin
                run++;
                if (run == len)
                begin
                    start = p + 1 - len;
                    return 1'b1;
                end
            end
        end
        return 1'b0;
    endfunction

    function automatic void rebuild_maps();
        int res;
        for (int p = 0; p < PAGES; p++)
        begin
            page_used[p] = 1'b0;
            page_user[p] = 1'b0;
        end
        managed_cnt = (reg_total > PAGES) ? PAGES : reg_total;
        free_cnt = managed_cnt;
        res = (reg_rsv > managed_cnt) ? managed_cnt : reg_rsv;
        for (int p = 0; p < res; p++)
            claim_page(p, 1'b0);
        pool_on = 1'b0;
        pool_lo = 0;
        pool_hi = 0;
        if (reg_rsv + reg_pool < managed_cnt)
        begin
            pool_on = 1'b1;
            pool_lo = reg_rsv;
            pool_hi = reg_rsv + reg_pool;
            for (int p = pool_lo; p < pool_hi; p++)
                claim_page(p, 1'b0);
        end
        if (managed_cnt > TOP_RSV)
            for (int p = managed_cnt - TOP_RSV; p < managed_cnt; p++)
                claim_page(p, 1'b0);
    endfunction

    // Apply one request to the shadow and return the response it must give.
    function automatic rsp_t allocate_step(req_t r);
        rsp_t o;
        int   len;
        int   idx;
        int   start;
        bit   found;
        o = '0;
        len = r.run_length;
        idx = r.page_index;
        start = 0;
        case (r.req_type)
            REQ_INIT:
                rebuild_maps();
            REQ_KRUN, REQ_URUN:
            begin
                if (len == 0 || len > RUN_MAX || len > managed_cnt)
                    o.status = STAT_BAD;
                else if (first_fit(len, start))
                begin
                    for (int p = start; p < start + len; p++)
                        claim_page(p, r.req_type == REQ_URUN);
                end
                else
                begin
                    o.status = STAT_NOSPACE;
                    start = 0;
                end
            end
            REQ_PTAB:
            begin
                found = 1'b0;
                if (pool_on)
                    for (int p = pool_lo; p < pool_hi && p < managed_cnt && !found; p++)
                        if (!page_used[p])
                        begin
                            claim_page(p, 1'b0);
                            start = p;
                            found = 1'b1;
                        end
                if (!found)
                begin
                    if (managed_cnt >= 1 && first_fit(1, start))
                        claim_page(start, 1'b0);
                    else
                    begin
                        o.status = (managed_cnt == 0) ? STAT_BAD : STAT_NOSPACE;
                        start = 0;
                    end
                end
            end
            REQ_FREE:
            begin
                if (idx >= managed_cnt)
                    o.status = STAT_BAD;
                else if (page_used[idx])
                begin
                    page_used[idx] = 1'b0;
                    free_cnt++;
                end
            end
            REQ_QUERY:
            begin
                if (idx >= managed_cnt)
                    o.status = STAT_BAD;
                else
                    o.is_user = page_user[idx];
            end
            default:
                o.status = STAT_BAD;
        endcase
        o.page_start = start[15:0];
        o.free_pages = free_cnt[16:0];
        return o;
    endfunction

    // Queue a request together with the response it must produce.
    task automatic push_req(logic [2:0] kind, int len, int idx);
        req_t r;
        r.req_type   = kind;
        r.run_length = len[8:0];
        r.page_index = idx[15:0];
        pending_reqs.push_back(r);
        expected_rsps.push_back(allocate_step(r));
    endtask

    // Pick a page index; half the picks try for a page in use so frees hit live runs.
    function automatic int pick_page();
        int sel;
        int p;
        sel = $urandom_range(0, 99);
        if (managed_cnt == 0 || sel >= 85)
            return $urandom_range(0, 65535);
        if (sel >= 75 && managed_cnt < PAGES)
            return $urandom_range(managed_cnt, 65535);
        if (sel < 50)
            for (int t = 0; t < 8; t++)
            begin
                p = $urandom_range(0, managed_cnt - 1);
                if (page_used[p])
                    return p;
            end
        return $urandom_range(0, managed_cnt - 1);
    endfunction

    function automatic int pick_len();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 60)
            return $urandom_range(1, 4);
        if (sel < 80)
            return $urandom_range(5, 64);
        if (sel < 90)
            return $urandom_range(65, 256);
        if (sel < 95)
            return 0;
        return $urandom_range(257, 511);
    endfunction

    task automatic random_reqs(int n);
        int sel;
        for (int i = 0; i < n; i++)
        begin
            sel = $urandom_range(0, 99);
            if (sel < 30)
                push_req(($urandom_range(0, 1) != 0) ? REQ_URUN : REQ_KRUN,
                         pick_len(), $urandom_range(0, 65535));
            else if (sel < 45)
                push_req(REQ_PTAB, $urandom_range(0, 511), $urandom_range(0, 65535));
            else if (sel < 75)
                push_req(REQ_FREE, $urandom_range(0, 511), pick_page());
            else if (sel < 93)
                push_req(REQ_QUERY, $urandom_range(0, 511), pick_page());
            else if (sel < 96)
                push_req(REQ_INIT, $urandom_range(0, 511), $urandom_range(0, 65535));
            else
                push_req($urandom_range(6, 7), $urandom_range(0, 511),
                         $urandom_range(0, 65535));
        end
    endtask

    // Hold until every queued request went in and every response came back.
    task automatic wait_idle();
        while (pending_reqs.size() != 0 || expected_rsps.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    // Register write: setup phase, then access phase.
    task automatic reg_write(logic [1:0] which, int value);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {which, 2'b00};
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (which)
            REG_TOTAL: reg_total = value & 32'h1FFFF;
            REG_RSV:   reg_rsv   = value & 32'h1FFFF;
            default:   reg_pool  = value & 32'h1FFFF;
        endcase
    endtask

    task automatic new_layout(int total, int rsv, int pool, int n);
        wait_idle();
        reg_write(REG_TOTAL, total);
        reg_write(REG_RSV, rsv);
        reg_write(REG_POOL, pool);
        push_req(REQ_INIT, 0, 0);
        random_reqs(n);
    endtask

    // ------------------------------------------------------------------
    // Clock and reset
    // ------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        rst_n   = 1'b0;
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = '0;
        pwdata  = '0;
        req_ch.valid   = 1'b0;
        req_ch.payload = '0;
        rsp_ch.ready   = 1'b0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
    end

    // ------------------------------------------------------------------
    // Request driver: bursts of random length, random gaps after them.
    // valid stays up until the transaction is taken.
    // ------------------------------------------------------------------
    logic req_fire;
    int   burst_left;
    int   gap_left;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            req_fire <= 1'b0;
        else
            req_fire <= req_ch.valid && req_ch.ready;
    end

    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (req_fire)
            begin
                void'(pending_reqs.pop_front());
                burst_left--;
                if (burst_left <= 0)
                begin
                    burst_left = $urandom_range(1, 16);
                    gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
                end
            end
            // Only change what is offered once the last offer was taken.
            if (!req_ch.valid || req_fire)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    req_ch.valid <= 1'b0;
                end
                else if (pending_reqs.size() != 0)
                begin
                    req_ch.valid   <= 1'b1;
                    req_ch.payload <= pending_reqs[0];
                end
                else
                    req_ch.valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Response receiver: stall rate is redrawn as the cycle counter advances, including
    // stretches with no stall; a kick from the sequence forces a long hold.
    // ------------------------------------------------------------------
    int stall_pct;
    int hold_left;

    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (cycle_cnt % 64 == 0)
                case ($urandom_range(0, 3))
                    0, 1: stall_pct = 0;
                    2:    stall_pct = 30;
                    default: stall_pct = 75;
                endcase
            if (hold_kick != hold_seen)
            begin
                hold_seen = hold_kick;
                hold_left = 600;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_ch.ready <= 1'b0;
            end
            else
                rsp_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    // ------------------------------------------------------------------
    // Response checker: compare each transaction against the oldest
    // expectation, field by field.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        rsp_t got;
        rsp_t want;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            got = rsp_ch.payload;
            if (expected_rsps.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("[%0t] unexpected response %p", $realtime, got);
            end
            else
            begin
                want = expected_rsps.pop_front();
                if (got.status !== want.status || got.page_start !== want.page_start
                    || got.is_user !== want.is_user || got.free_pages !== want.free_pages)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("[%0t] mismatch: exp st=%0d start=%0d user=%0d free=%0d, got st=%0d start=%0d user=%0d free=%0d",
                                 $realtime, want.status, want.page_start, want.is_user,
                                 want.free_pages, got.status, got.page_start,
                                 got.is_user, got.free_pages);
                end
            end
        end
    end

    // Watchdog: drop the run if it never drains.
    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_CAP)
        begin
            $display("** bitmap_page_allocator: FAILED **");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial
    begin
        mismatches  = 0;
        cycle_cnt   = 0;
        hold_kick   = 0;
        hold_seen   = 0;
        hold_left   = 0;
        stall_pct   = 0;
        burst_left  = 1;
        gap_left    = 0;
        reg_total   = TOTAL_RST;
        reg_rsv     = RSV_RST;
        reg_pool    = POOL_RST;
        managed_cnt = 0;
        free_cnt    = 0;
        pool_on     = 1'b0;
        pool_lo     = 0;
        pool_hi     = 0;
        for (int p = 0; p < PAGES; p++)
        begin
            page_used[p] = 1'b0;
            page_user[p] = 1'b0;
        end
        @(posedge rst_n);

        // Before any init nothing is managed: every request is rejected.
        push_req(REQ_FREE, 0, 0);
        push_req(REQ_QUERY, 0, 0);
        push_req(REQ_KRUN, 1, 0);
        push_req(REQ_PTAB, 0, 0);
        push_req(3'd7, 511, 65535);

        // Reset layout: full size, pool at page 0.
        push_req(REQ_INIT, 0, 0);
        push_req(REQ_KRUN, 0, 0);
        push_req(REQ_KRUN, 256, 0);
        push_req(REQ_URUN, 257, 0);
        push_req(REQ_URUN, 511, 0);
        push_req(REQ_URUN, 3, 0);
        push_req(REQ_PTAB, 0, 0);
        push_req(REQ_QUERY, 0, 4096);
        push_req(REQ_QUERY, 0, 0);
        push_req(REQ_FREE, 0, 4097);
        push_req(REQ_FREE, 0, 4097);
        push_req(REQ_QUERY, 0, 4097);
        push_req(REQ_FREE, 0, 65535);
        push_req(REQ_QUERY, 0, 65535);
        push_req(REQ_FREE, 0, 0);
        push_req(REQ_PTAB, 0, 0);
        push_req(3'd6, 0, 0);
        random_reqs(20);

        // Smallest total, empty pool: page-table requests fall back.
        new_layout(17, 0, 0, 60);
        push_req(REQ_FREE, 0, 17);
        push_req(REQ_QUERY, 0, 65535);
        push_req(REQ_KRUN, 18, 0);

        // Small map, crowded: long receiver hold while requests keep coming.
        new_layout(100, 10, 20, 150);
        hold_kick++;

        new_layout(300, 0, 50, 150);

        // Reserve and pool both at the full page count: nothing is free at init.
        new_layout(1000, 65536, 65536, 60);

        // Pool that does not fit: inactive.
        new_layout(64, 5, 100, 100);
        hold_kick++;

        new_layout(2000, 30, 64, 180);

        // Total register at its top value: capped to the full map.
        new_layout(32'h1FFFF, 0, 0, 40);

        wait_idle();
        if (mismatches == 0)
            $display("** bitmap_page_allocator: PASSED **");
        else
            $display("** bitmap_page_allocator: FAILED **");
        $finish;
    end

endmodule
